// ----- hw/rtl/sv39ptw_pkg.sv -----
// shared widths, codes and types of the sv39 page table walker
`default_nettype none

package sv39ptw_pkg;

   // field widths
   localparam int VA_W       = 39;
   localparam int PPN_W      = 44;
   localparam int PA_W       = 56;
   localparam int IDX_W      = 12;
   localparam int PTE_W      = 64;
   localparam int STATUS_W   = 3;
   localparam int ROOT_W     = 3;
   localparam int VPN_W      = 9;
   localparam int OFFSET_W   = 12;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 64;

   // entries in one table page
   localparam int ENTRIES_PER_PAGE = 512;

   // table entry bit positions
   localparam int PTE_V   = 0;
   localparam int PTE_R   = 1;
   localparam int PTE_X   = 3;
   localparam int PPN_LSB = 10;
   localparam int PPN_MSB = 53;

   // operation codes
   localparam logic OP_WRITE     = 1'b0;
   localparam logic OP_TRANSLATE = 1'b1;

   // result status codes
   localparam logic [STATUS_W-1:0] STATUS_OK      = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_LIMIT   = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_INVALID = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_NO_PERM = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_WINDOW  = 3'd4;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ROOT_PAGE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_BASE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_VA_LIMIT    = 2'd2;

   // reset value of the address limit, 2^38
   localparam logic [VA_W-1:0] VA_LIMIT_RESET = 39'h40_0000_0000;

   // configuration seen by the walker
   typedef struct packed {
      logic [ROOT_W-1:0] root_page;
      logic [PPN_W-1:0]  window_base_ppn;
      logic [VA_W-1:0]   va_limit;
   } cfg_type;

endpackage

`default_nettype wire

// ----- hw/rtl/sv39ptw_if.sv -----
// valid/ready channel interfaces: request, response and register write
`default_nettype none

interface sv39ptw_req_if import sv39ptw_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             op;
   logic [IDX_W-1:0] entry_index;
   logic [PTE_W-1:0] entry_value;
   logic [VA_W-1:0]  vaddr;

   modport source(output valid, op, entry_index, entry_value, vaddr, input ready);
   modport sink(input valid, op, entry_index, entry_value, vaddr, output ready);
endinterface

interface sv39ptw_rsp_if import sv39ptw_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [PA_W-1:0]     paddr;
   logic [STATUS_W-1:0] status;

   modport source(output valid, paddr, status, input ready);
   modport sink(input valid, paddr, status, output ready);
endinterface

interface sv39ptw_csr_if import sv39ptw_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/sv39ptw_store.sv -----
// page table entry memory: one write port, one read port, registered read data
`default_nettype none

module sv39ptw_store import sv39ptw_pkg::*; #(
   parameter int DEPTH  = 4096,
   parameter int ADDR_W = 12
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [PTE_W-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output      logic [PTE_W-1:0]  rd_data
);

   logic [PTE_W-1:0] mem [DEPTH];
   logic [PTE_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, data held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/sv39ptw_walk.sv -----
// walk sequencer: clearing pass, entry writes, three-level lookup, response register
`default_nettype none

module sv39ptw_walk import sv39ptw_pkg::*; #(
   parameter int TABLE_PAGES = 8,
   parameter int PAGE_W      = 3,
   parameter int ADDR_W      = 12
) (
   input  wire logic              clock,
   input  wire logic              reset,
   sv39ptw_req_if.sink            req_ch,
   sv39ptw_rsp_if.source          rsp_ch,
   input  wire cfg_type           cfg,
   output      logic              wr_en,
   output      logic [ADDR_W-1:0] wr_addr,
   output      logic [PTE_W-1:0]  wr_data,
   output      logic              rd_en,
   output      logic [ADDR_W-1:0] rd_addr,
   input  wire logic [PTE_W-1:0]  rd_data
);

   localparam int DEPTH = TABLE_PAGES * ENTRIES_PER_PAGE;

   typedef enum logic [4:0] {
      ST_CLEAR = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_LVL2  = 5'b00100,
      ST_LVL1  = 5'b01000,
      ST_LVL0  = 5'b10000
   } state_type;

   state_type           state_ff, state_in;
   logic [ADDR_W-1:0]   clr_ff, clr_in;
   logic [VA_W-1:0]     vaddr_ff, vaddr_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [PA_W-1:0]     rsp_paddr_ff, rsp_paddr_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;

   logic                slot_free;
   logic                accept;
   logic                rsp_load;
   logic [PA_W-1:0]     load_paddr;
   logic [STATUS_W-1:0] load_status;
   logic [15:0]         idx_wide;
   logic [7:0]          root_wide;
   logic [PPN_W-1:0]    pte_ppn;
   logic [PPN_W:0]      ppn_diff;
   logic                ptr_outside;
   logic [PAGE_W-1:0]   next_page;

   // output slot is free when empty or being drained this cycle
   assign slot_free    = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = (state_ff == ST_IDLE) && slot_free;
   assign accept       = req_ch.valid && req_ch.ready;

   // index and page helpers
   assign idx_wide  = 16'(req_ch.entry_index);
   assign root_wide = 8'(cfg.root_page);

   // pointer range check against the table window
   assign pte_ppn     = rd_data[PPN_MSB:PPN_LSB];
   assign ppn_diff    = {1'b0, pte_ppn} - {1'b0, cfg.window_base_ppn};
   assign ptr_outside = ppn_diff[PPN_W] || (ppn_diff[PPN_W-1:0] >= PPN_W'(TABLE_PAGES));
   assign next_page   = ppn_diff[PAGE_W-1:0];

   // sequencer
   always_comb begin
      state_in    = state_ff;
      clr_in      = clr_ff;
      vaddr_in    = vaddr_ff;
      wr_en       = 1'b0;
      wr_addr     = clr_ff;
      wr_data     = '0;
      rd_en       = 1'b0;
      rd_addr     = '0;
      rsp_load    = 1'b0;
      load_paddr  = '0;
      load_status = STATUS_OK;
      unique case (state_ff)
         ST_CLEAR: begin
            wr_en  = 1'b1;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == ADDR_W'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               vaddr_in = req_ch.vaddr;
               if (req_ch.op == OP_WRITE) begin
                  // writes past the store are dropped
                  wr_en    = 32'(req_ch.entry_index) < 32'(DEPTH);
                  wr_addr  = idx_wide[ADDR_W-1:0];
                  wr_data  = req_ch.entry_value;
                  rsp_load = 1'b1;
               end else if (req_ch.vaddr > cfg.va_limit) begin
                  rsp_load    = 1'b1;
                  load_status = STATUS_LIMIT;
               end else if (32'(cfg.root_page) >= 32'(TABLE_PAGES)) begin
                  rsp_load    = 1'b1;
                  load_status = STATUS_WINDOW;
               end else begin
                  rd_en    = 1'b1;
                  rd_addr  = {root_wide[PAGE_W-1:0], req_ch.vaddr[38:30]};
                  state_in = ST_LVL2;
               end
            end
         end
         ST_LVL2, ST_LVL1: begin
            if (!rd_data[PTE_V] || ptr_outside) begin
               // error ends the walk once the slot is free
               if (slot_free) begin
                  rsp_load    = 1'b1;
                  load_status = !rd_data[PTE_V] ? STATUS_INVALID : STATUS_WINDOW;
                  state_in    = ST_IDLE;
               end
            end else begin
               rd_en = 1'b1;
               if (state_ff == ST_LVL2) begin
                  rd_addr  = {next_page, vaddr_ff[29:21]};
                  state_in = ST_LVL1;
               end else begin
                  rd_addr  = {next_page, vaddr_ff[20:12]};
                  state_in = ST_LVL0;
               end
            end
         end
         ST_LVL0: begin
            if (slot_free) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
               if (!rd_data[PTE_V]) begin
                  load_status = STATUS_INVALID;
               end else if (rd_data[PTE_X:PTE_R] == '0) begin
                  load_status = STATUS_NO_PERM;
               end else begin
                  load_paddr = {pte_ppn, vaddr_ff[OFFSET_W-1:0]};
               end
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // response register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_paddr_in  = rsp_paddr_ff;
      rsp_status_in = rsp_status_ff;
      if (rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_paddr_in  = load_paddr;
         rsp_status_in = load_status;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      vaddr_ff      <= vaddr_in;
      rsp_paddr_ff  <= rsp_paddr_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_ch.valid  = rsp_valid_ff;
   assign rsp_ch.paddr  = rsp_paddr_ff;
   assign rsp_ch.status = rsp_status_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/sv39_page_table_walk.sv -----
// Sv39 page table walker over a local page table store.
//
// req_ch carries one item per handshake: op 0 writes entry_value to store
// index entry_index (page * 512 + slot), op 1 translates vaddr. Every item
// gives exactly one item on rsp_ch: paddr and status (0 ok, 1 over limit,
// 2 invalid entry, 3 leaf without R/W/X, 4 root or pointer outside the window).
// csr_ch writes root_page, window_base_ppn and va_limit by index; it is
// always ready and should be used only while the walker is idle.
// A write, or a translation rejected by the limit or root check, is
// answered in the cycle after it is taken. A full walk makes three dependent
// reads, one per level, of the single read port of the entry memory, each
// address built from the entry read before; the accept cycle, LVL2 and
// LVL1 issue them and LVL0 loads the result. A new item is taken in the
// cycle after a result is loaded; writes run at one per cycle while rsp_ch
// is ready. After reset the memory is cleared one entry per cycle, all
// TABLE_PAGES * 512 entries (4096 by default), with req_ch not ready.
// A stalled rsp_ch holds its item in the output register; the walker stays
// idle and takes no new item until the slot frees.
`default_nettype none

module sv39_page_table_walk import sv39ptw_pkg::*; #(
   parameter int TABLE_PAGES = 8
) (
   input  wire logic     clock,
   input  wire logic     reset,
   sv39ptw_req_if.sink   req_ch,
   sv39ptw_rsp_if.source rsp_ch,
   sv39ptw_csr_if.sink   csr_ch
);

   localparam int PAGE_W = (TABLE_PAGES > 1) ? $clog2(TABLE_PAGES) : 1;
   localparam int ADDR_W = PAGE_W + VPN_W;
   localparam int DEPTH  = TABLE_PAGES * ENTRIES_PER_PAGE;

   logic [ROOT_W-1:0] root_page_ff;
   logic [PPN_W-1:0]  window_base_ff;
   logic [VA_W-1:0]   va_limit_ff;
   cfg_type           cfg;

   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [PTE_W-1:0]  wr_data;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [PTE_W-1:0]  rd_data;

   // configuration registers
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         root_page_ff   <= '0;
         window_base_ff <= '0;
         va_limit_ff    <= VA_LIMIT_RESET;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            CSR_ROOT_PAGE:   root_page_ff   <= csr_ch.data[ROOT_W-1:0];
            CSR_WINDOW_BASE: window_base_ff <= csr_ch.data[PPN_W-1:0];
            CSR_VA_LIMIT:    va_limit_ff    <= csr_ch.data[VA_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign cfg.root_page       = root_page_ff;
   assign cfg.window_base_ppn = window_base_ff;
   assign cfg.va_limit        = va_limit_ff;

   // walk sequencer
   sv39ptw_walk #(
      .TABLE_PAGES (TABLE_PAGES),
      .PAGE_W      (PAGE_W),
      .ADDR_W      (ADDR_W)
   ) u_walk (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .rsp_ch  (rsp_ch),
      .cfg     (cfg),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // entry memory
   sv39ptw_store #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

endmodule

`default_nettype wire
